[hw/rtl/scp_pkg.sv]
`timescale 1ns / 1ps

package scp_pkg;

    localparam int MAX_LEN     = 128;
    localparam int VALUE_W     = 8;
    localparam int CFG_W       = 8;
    localparam int CNT_W       = $clog2(MAX_LEN + 2);
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // word index of the sequence length register
    localparam logic [PADDR_W-3:0] REG_SEQ_LEN = '0;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               range_bad;
    } item_t;

    typedef struct packed {
        logic             clear;
        logic [CNT_W-1:0] n;
    } seq_ctl_t;

endpackage

[hw/rtl/stack_permutation_checker.sv]
`timescale 1ns / 1ps
// Results are registered in out_valid, still_possible and sequence_done;
// a value above the next number to push first runs the push state, which stores each
// smaller number on the stack. Items wait while out_stall holds a result, and after a
// pop that leaves a stored entry on top (stack memory read to refresh the top).
// Reset: control state clears at once; the stack memory is not cleared.
module stack_permutation_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scp_pkg::PADDR_W-1:0]   paddr,
    input  logic [scp_pkg::PDATA_W-1:0]   pwdata,
    output logic [scp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scp_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          still_possible,
    output logic                          sequence_done
);

    scp_pkg::seq_ctl_t ctl;
    scp_pkg::item_t    push_item;
    scp_pkg::item_t    head_item;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;

    scp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item),
        .ctl      (ctl)
    );

    scp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    scp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .q_valid        (q_valid),
        .q_item         (head_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .still_possible (still_possible),
        .sequence_done  (sequence_done)
    );

endmodule

[hw/rtl/scp_front.sv]
`timescale 1ns / 1ps

module scp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scp_pkg::PADDR_W-1:0]   paddr,
    input  logic [scp_pkg::PDATA_W-1:0]   pwdata,
    output logic [scp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scp_pkg::VALUE_W-1:0]   value,
    input  logic                          q_full,
    output logic                          q_push,
    output scp_pkg::item_t                q_item,
    output scp_pkg::seq_ctl_t             ctl
);

    logic [scp_pkg::CFG_W-1:0] seq_len_reg;
    logic [scp_pkg::CNT_W-1:0] n_eff_reg;
    logic [scp_pkg::CNT_W-1:0] n_eff_next;
    logic [scp_pkg::CFG_W-1:0] wdata;
    logic                      reg_hit;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[scp_pkg::PADDR_W-1:2] == scp_pkg::REG_SEQ_LEN);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign wdata   = pwdata[scp_pkg::CFG_W-1:0];
    assign prdata  = reg_hit ? scp_pkg::PDATA_W'(seq_len_reg) : '0;

    // zero acts as one, anything above the store acts as its size
    always_comb
    begin
        if (wdata == '0)
        begin
            n_eff_next = scp_pkg::CNT_W'(1);
        end
        else if (32'(wdata) > scp_pkg::MAX_LEN)
        begin
            n_eff_next = scp_pkg::CNT_W'(scp_pkg::MAX_LEN);
        end
        else
        begin
            n_eff_next = scp_pkg::CNT_W'(wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= scp_pkg::CFG_W'(1);
            n_eff_reg   <= scp_pkg::CNT_W'(1);
        end
        else if (cfg_wr)
        begin
            seq_len_reg <= wdata;
            n_eff_reg   <= n_eff_next;
        end
    end

    assign ctl.clear = cfg_wr;
    assign ctl.n     = n_eff_reg;

    assign in_stall        = q_full;
    assign q_push          = in_valid && !q_full;
    assign q_item.value    = value;
    assign q_item.range_bad = (value == '0) || (32'(value) > 32'(n_eff_reg));

endmodule

[hw/rtl/scp_queue.sv]
`timescale 1ns / 1ps

module scp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scp_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output scp_pkg::item_t head_item
);

    scp_pkg::item_t             entry_reg [scp_pkg::QUEUE_DEPTH];
    logic [scp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [scp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [scp_pkg::QCNT_W-1:0] count_reg;
    logic                       do_push;
    logic                       do_pop;

    assign full       = (count_reg == scp_pkg::QCNT_W'(scp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == scp_pkg::QUEUE_DEPTH - 1) ? '0
                              : wr_ptr_reg + scp_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == scp_pkg::QUEUE_DEPTH - 1) ? '0
                              : rd_ptr_reg + scp_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + scp_pkg::QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - scp_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/scp_back.sv]
`timescale 1ns / 1ps

module scp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  scp_pkg::seq_ctl_t           ctl,
    input  logic                        q_valid,
    input  scp_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        still_possible,
    output logic                        sequence_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [scp_pkg::CNT_W-1:0]   depth_reg, depth_next;
    logic [scp_pkg::CNT_W-1:0]   ntp_reg, ntp_next;
    logic [scp_pkg::CNT_W-1:0]   seen_reg, seen_next;
    logic                        rej_reg, rej_next;
    logic [scp_pkg::VALUE_W-1:0] top_reg, top_next;
    logic [scp_pkg::CNT_W-1:0]   item_reg, item_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        still_reg, still_next;
    logic                        done_reg, done_next;

    logic [scp_pkg::VALUE_W-1:0] mem [scp_pkg::MAX_LEN];
    logic                        wr_en;
    logic [scp_pkg::ADDR_W-1:0]  wr_addr;
    logic [scp_pkg::VALUE_W-1:0] wr_data;
    logic                        rd_en;
    logic [scp_pkg::ADDR_W-1:0]  rd_addr;
    logic [scp_pkg::VALUE_W-1:0] rd_data_reg;

    logic                        out_free;
    logic [scp_pkg::CNT_W-1:0]   v_ext;
    logic [scp_pkg::CNT_W-1:0]   seen_inc;
    logic [scp_pkg::CNT_W-1:0]   depth_m2;
    logic                        seq_end;
    logic                        finish;
    logic                        fin_rej;

    assign out_free = !out_valid_reg || !out_stall;
    // only used once the range check has passed, so the value fits
    assign v_ext    = scp_pkg::CNT_W'(q_item.value);
    assign seen_inc = seen_reg + scp_pkg::CNT_W'(1);
    assign seq_end  = (seen_inc >= ctl.n);
    assign depth_m2 = depth_reg - scp_pkg::CNT_W'(2);
    assign wr_addr  = depth_reg[scp_pkg::ADDR_W-1:0];
    assign wr_data  = scp_pkg::VALUE_W'(ntp_reg);
    assign rd_addr  = depth_m2[scp_pkg::ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        ntp_next       = ntp_reg;
        seen_next      = seen_reg;
        rej_next       = rej_reg;
        top_next       = top_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg;
        still_next     = still_reg;
        done_next      = done_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        finish         = 1'b0;
        fin_rej        = rej_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (rej_reg || q_item.range_bad)
                    begin
                        finish  = 1'b1;
                        fin_rej = 1'b1;
                    end
                    else if (v_ext == ntp_reg)
                    begin
                        finish   = 1'b1;
                        ntp_next = ntp_reg + scp_pkg::CNT_W'(1);
                    end
                    else if (v_ext > ntp_reg)
                    begin
                        item_next  = v_ext;
                        state_next = ST_PUSH;
                    end
                    else if (depth_reg != '0 && top_reg == q_item.value)
                    begin
                        finish     = 1'b1;
                        depth_next = depth_reg - scp_pkg::CNT_W'(1);
                        if (depth_reg >= scp_pkg::CNT_W'(2))
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        finish  = 1'b1;
                        fin_rej = 1'b1;
                    end
                end
            end
            ST_PUSH:
            begin
                // the value itself is popped straight away, never stored
                if (ntp_reg == item_reg)
                begin
                    if (out_free)
                    begin
                        finish     = 1'b1;
                        ntp_next   = ntp_reg + scp_pkg::CNT_W'(1);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    depth_next = depth_reg + scp_pkg::CNT_W'(1);
                    ntp_next   = ntp_reg + scp_pkg::CNT_W'(1);
                    top_next   = scp_pkg::VALUE_W'(ntp_reg);
                end
            end
            ST_LOAD:
            begin
                top_next   = rd_data_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            out_valid_next = 1'b1;
            still_next     = !fin_rej;
            done_next      = seq_end;
            if (seq_end)
            begin
                depth_next = '0;
                ntp_next   = scp_pkg::CNT_W'(1);
                seen_next  = '0;
                rej_next   = 1'b0;
                state_next = ST_IDLE;
            end
            else
            begin
                seen_next = seen_inc;
                rej_next  = fin_rej;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (ctl.clear)
        begin
            depth_next = '0;
            ntp_next   = scp_pkg::CNT_W'(1);
            seen_next  = '0;
            rej_next   = 1'b0;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        item_reg   <= item_next;
        still_reg  <= still_next;
        done_reg   <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            ntp_reg       <= scp_pkg::CNT_W'(1);
            seen_reg      <= '0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            ntp_reg       <= ntp_next;
            seen_reg      <= seen_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign still_possible = still_reg;
    assign sequence_done  = done_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg < scp_pkg::CNT_W'(scp_pkg::MAX_LEN))
        else $error("stack depth beyond store");

    a_push_sane: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |-> !rej_reg && ntp_reg <= item_reg)
        else $error("push run on rejected sequence or past target");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
        finish && seq_end |=> seen_reg == '0 && depth_reg == '0 && !rej_reg)
        else $error("sequence state not cleared at end");

    a_ntp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ntp_reg != '0)
        else $error("next-to-push counter at zero");

endmodule
